FILE: rtl/core/etcp_pkg.sv
// Package for the exhaustive two-cluster partition block.
// Holds widths, controller commands and shared types; no dependencies.
package etcp_pkg;
    localparam int CoordW = 16;
    localparam int MaskW  = 15;
    localparam int CostW  = 36;
    localparam int CntW   = 5;
    localparam int SumW   = 20;
    localparam int SqW    = 37;
    localparam int NumW   = 42;

    typedef struct packed {
        logic load;
        logic mask_start;
        logic pt_step;
        logic pt_last;
        logic div_start;
        logic div_step;
        logic div_done;
        logic cmp;
        logic out_load;
    } etcp_cmd_t;
endpackage

FILE: rtl/core/etcp_datapath.sv
// Datapath: point registers, per-mask accumulators, a restoring divider and
// the best-so-far compare. Depends on etcp_pkg.
module etcp_datapath #(
    parameter int NUM_POINTS = 10,
    parameter int IdxW = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  etcp_pkg::etcp_cmd_t cmd,
    input  logic [IdxW-1:0] load_idx,
    input  logic [IdxW-1:0] pt_idx,
    input  logic [5:0] div_idx,
    input  logic div_sel,
    input  logic [etcp_pkg::CoordW-1:0] coord_x,
    input  logic [etcp_pkg::CoordW-1:0] coord_y,
    output logic last_mask,
    output logic [etcp_pkg::MaskW-1:0] best_mask,
    output logic [etcp_pkg::CostW-1:0] min_cost
);
    import etcp_pkg::*;

    logic [CoordW-1:0] px_reg [NUM_POINTS];
    logic [CoordW-1:0] py_reg [NUM_POINTS];
    logic [MaskW-1:0] mask_reg, bmask_reg, omask_reg;
    logic [CostW-1:0] bcost_reg, ocost_reg;
    logic first_reg;
    logic [CntW-1:0] c_reg [2];
    logic [SumW-1:0] sx_reg [2];
    logic [SumW-1:0] sy_reg [2];
    logic [SqW-1:0] sq_reg [2];
    logic [NumW-1:0] num_reg, quo_reg;
    logic [CntW-1:0] rem_reg;
    logic [CostW+1:0] tot_reg;
    logic [CntW-1:0] dc;
    logic [CntW:0] trial;
    logic k;
    logic [MaskW:0] mask_ext;
    logic [CoordW-1:0] x, y;
    logic [2*SumW-1:0] sxs, sys;
    logic [NumW-1:0] cs;
    logic [CostW+1:0] tot_next;
    logic [CostW-1:0] cost;

    assign x = px_reg[pt_idx];
    assign y = py_reg[pt_idx];
    assign mask_ext = {1'b0, mask_reg};
    assign k = mask_ext[IdxW'(NUM_POINTS-1) - pt_idx];
    assign last_mask = (mask_reg == MaskW'((1 << (NUM_POINTS-1)) - 1));
    assign dc = c_reg[div_sel];
    assign sxs = sx_reg[div_sel] * sx_reg[div_sel];
    assign sys = sy_reg[div_sel] * sy_reg[div_sel];
    assign cs = NumW'(dc) * NumW'(sq_reg[div_sel]);
    assign trial = {rem_reg, num_reg[6'(NumW-1) - div_idx]};
    assign tot_next = tot_reg + (CostW+2)'(quo_reg);
    assign cost = (tot_reg > (CostW+2)'({CostW{1'b1}})) ? {CostW{1'b1}}
                                                        : tot_reg[CostW-1:0];
    assign best_mask = omask_reg;
    assign min_cost = ocost_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg[load_idx] <= coord_x;
            py_reg[load_idx] <= coord_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            first_reg <= 1'b1;
            bmask_reg <= '0;
            bcost_reg <= '0;
            omask_reg <= '0;
            ocost_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                mask_reg  <= MaskW'(1);
                first_reg <= 1'b1;
            end
            if (cmd.cmp)
            begin
                if (first_reg || cost < bcost_reg)
                begin
                    bcost_reg <= cost;
                    bmask_reg <= mask_reg;
                end
                first_reg <= 1'b0;
                mask_reg  <= mask_reg + MaskW'(1);
            end
            if (cmd.out_load)
            begin
                omask_reg <= bmask_reg;
                ocost_reg <= bcost_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mask_start)
        begin
            for (int i = 0; i < 2; i++)
            begin
                c_reg[i]  <= '0;
                sx_reg[i] <= '0;
                sy_reg[i] <= '0;
                sq_reg[i] <= '0;
            end
            tot_reg <= '0;
        end
        else if (cmd.pt_step)
        begin
            c_reg[k]  <= c_reg[k] + CntW'(1);
            sx_reg[k] <= sx_reg[k] + SumW'(x);
            sy_reg[k] <= sy_reg[k] + SumW'(y);
            sq_reg[k] <= sq_reg[k] + SqW'(x * x) + SqW'(y * y);
        end
        if (cmd.div_start)
        begin
            num_reg <= (cs > NumW'(sxs) + NumW'(sys)) ? cs - NumW'(sxs) - NumW'(sys) : '0;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, dc})
            begin
                rem_reg <= CntW'(trial - {1'b0, dc});
                quo_reg <= {quo_reg[NumW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[CntW-1:0];
                quo_reg <= {quo_reg[NumW-2:0], 1'b0};
            end
        end
        if (cmd.div_done)
            tot_reg <= (dc == '0) ? tot_reg : tot_next;
    end

    logic unused;
    assign unused = cmd.pt_last;
endmodule

FILE: rtl/core/etcp_ctrl.sv
// Controller state machine: load count, per-mask point sweep and divider steps.
// Depends on etcp_pkg.
module etcp_ctrl #(
    parameter int NUM_POINTS = 10,
    parameter int IdxW = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  logic last_mask,
    output etcp_pkg::etcp_cmd_t cmd,
    output logic [IdxW-1:0] load_idx,
    output logic [IdxW-1:0] pt_idx,
    output logic [5:0] div_idx,
    output logic div_sel
);
    import etcp_pkg::*;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_PT   = 3'd2;
    localparam logic [2:0] S_DST  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DEND = 3'd5;
    localparam logic [2:0] S_CMP  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [IdxW-1:0] lidx_reg, pidx_reg;
    logic [5:0] didx_reg;
    logic sel_reg, ov_reg;
    logic acc;

    assign acc = in_valid && !in_stall;
    assign in_stall = (state_reg != S_LOAD);
    assign out_valid = ov_reg;
    assign load_idx = lidx_reg;
    assign pt_idx = pidx_reg;
    assign div_idx = didx_reg;
    assign div_sel = sel_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        cmd.load = acc;
        case (state_reg)
            S_LOAD:
                if (acc && lidx_reg == IdxW'(NUM_POINTS-1))
                    state_next = S_INIT;
            S_INIT:
            begin
                cmd.mask_start = 1'b1;
                state_next = S_PT;
            end
            S_PT:
            begin
                cmd.pt_step = 1'b1;
                cmd.pt_last = (pidx_reg == IdxW'(NUM_POINTS-1));
                if (cmd.pt_last)
                    state_next = S_DST;
            end
            S_DST:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (didx_reg == 6'(NumW-1))
                    state_next = S_DEND;
            end
            S_DEND:
            begin
                cmd.div_done = 1'b1;
                state_next = sel_reg ? S_CMP : S_DST;
            end
            S_CMP:
            begin
                cmd.cmp = 1'b1;
                state_next = last_mask ? S_OUT : S_INIT;
            end
            S_OUT:
                if (!ov_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_LOAD;
                end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            lidx_reg  <= '0;
            pidx_reg  <= '0;
            didx_reg  <= '0;
            sel_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (acc)
                lidx_reg <= (lidx_reg == IdxW'(NUM_POINTS-1)) ? '0 : lidx_reg + IdxW'(1);
            if (cmd.mask_start)
            begin
                pidx_reg <= '0;
                sel_reg  <= 1'b0;
            end
            if (cmd.pt_step)
                pidx_reg <= pidx_reg + IdxW'(1);
            if (cmd.div_start)
                didx_reg <= '0;
            if (cmd.div_step)
                didx_reg <= didx_reg + 6'd1;
            if (cmd.div_done)
                sel_reg <= ~sel_reg;
            if (cmd.out_load)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end
endmodule

FILE: rtl/core/exhaustive_two_cluster_partition.sv
// Exhaustive two-cluster partition of NUM_POINTS points by minimum squared error.
// Top level: joins etcp_ctrl and etcp_datapath; depends on etcp_pkg.
//
// Usage: points arrive one per beat on coord_x/coord_y (valid/stall). After
// the NUM_POINTS-th beat the block stalls its input and evaluates every mask
// from 1 to 2^(NUM_POINTS-1)-1. Each mask runs a sweep over all NUM_POINTS points
// to accumulate both clusters, then two serial divisions of 42 steps each, with setup,
// in the one-bit-per-cycle restoring divider, then the compare with the best so far.
// The result beat (best_mask, min_cost) is held in an output
// register; the input stays stalled while an earlier result is still
// waiting under out_stall. The loading of the next set of points starts
// once the result is in the output register.
// Reset clears the load count, the controller and the output valid. The point
// registers need no reset.
module exhaustive_two_cluster_partition #(
    parameter int NUM_POINTS = 10
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic [etcp_pkg::CoordW-1:0] coord_x,
    input  logic [etcp_pkg::CoordW-1:0] coord_y,
    output logic out_valid,
    input  logic out_stall,
    output logic [etcp_pkg::MaskW-1:0] best_mask,
    output logic [etcp_pkg::CostW-1:0] min_cost
);
    import etcp_pkg::*;

    localparam int IdxW = $clog2(NUM_POINTS);

    etcp_cmd_t cmd;
    logic [IdxW-1:0] load_idx, pt_idx;
    logic [5:0] div_idx;
    logic div_sel, last_mask;

    etcp_ctrl #(.NUM_POINTS(NUM_POINTS), .IdxW(IdxW)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .last_mask(last_mask),
        .cmd(cmd), .load_idx(load_idx), .pt_idx(pt_idx), .div_idx(div_idx),
        .div_sel(div_sel)
    );

    etcp_datapath #(.NUM_POINTS(NUM_POINTS), .IdxW(IdxW)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .load_idx(load_idx),
        .pt_idx(pt_idx), .div_idx(div_idx), .div_sel(div_sel),
        .coord_x(coord_x), .coord_y(coord_y), .last_mask(last_mask),
        .best_mask(best_mask), .min_cost(min_cost)
    );

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(best_mask) && $stable(min_cost))
        else $error("result changed under stall");
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pt_step || cmd.div_step) |-> in_stall)
        else $error("input open during search");
    a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> best_mask != '0)
        else $error("zero mask emitted");
`endif
endmodule
